FILE: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define NSCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NSCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NSCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NSCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/nscw_pkg.sv
`default_nettype none
package nscw_pkg;

  localparam int WIN_W  = 16;
  localparam int CNT_W  = 16;
  localparam int Q_W    = 16;
  localparam int DIV_W  = 32;
  localparam int DVS_W  = 17;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int CMP_W  = (2 * Q_W > WIN_W + 8) ? 2 * Q_W : WIN_W + 8;

  localparam logic [Q_W-1:0]   ALPHA_ONE = Q_W'(256);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [WIN_W-1:0] WIN_MAX   = '1;

  typedef enum logic [1:0] {
    REQ_DATA = 2'd0,
    REQ_NACK = 2'd1,
    REQ_TICK = 2'd2
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        pmin_present;
    logic [15:0] pmin_value;
  } nscw_in_t;

  typedef struct packed {
    logic [15:0] window_now;
    logic [15:0] threshold_now;
    logic [15:0] alpha_now;
  } nscw_out_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

  // EWMA: (7*old + sample) / 8
  function automatic logic [Q_W-1:0] ratio_blend(input logic [Q_W-1:0] r,
                                                 input logic [Q_W-1:0] s);
    logic [Q_W+2:0] acc;
    acc = ({3'b000, r} << 3) - {3'b000, r} + {3'b000, s};
    return acc[Q_W+2:3];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/nscw_chan_if.sv
`default_nettype none
interface nscw_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/nack_scaled_congestion_window.sv
`default_nettype none
`include "assert_macros.svh"
// Congestion window scaled by nack feedback. One item per event (data, nack,
// ratio tick); each item returns one result with window, threshold and alpha
// after the event. A nack that does not divide, an unknown code or a tick that
// does not divide (before the first nack, or with no nacks counted) go straight
// to the output state; data takes one registered 16x16 multiply, then compare;
// a nack that rescales alpha or an enabled tick with nacks runs the shared
// 32-step restoring divider and a finish state first. The input is not ready while an item is in work; a
// finished result waits in the output register while the next item is taken.
// A configuration write loads the window directly and is always accepted.
module nack_scaled_congestion_window (
  input  wire logic clk,
  input  wire logic rst_n,
  nscw_chan_if.sink   in_ch,
  nscw_chan_if.source out_ch,
  nscw_chan_if.sink   cfg_ch
);
  import nscw_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DATA, S_DIV, S_FIN, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [WIN_W-1:0]  window_r, window_nxt;
  logic [WIN_W-1:0]  thresh_r, thresh_nxt;
  logic [CNT_W-1:0]  avoid_r, avoid_nxt;
  logic [Q_W-1:0]    alpha_r, alpha_nxt;
  logic [Q_W-1:0]    ratio_r, ratio_nxt;
  logic [CNT_W-1:0]  nack_cnt_r, nack_cnt_nxt;
  logic [CNT_W-1:0]  data_cnt_r, data_cnt_nxt;
  logic              ticks_en_r, ticks_en_nxt;
  logic [2*Q_W-1:0]  prod_r, prod_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              div_alpha_r, div_alpha_nxt;
  logic              out_valid_r, out_valid_nxt;
  nscw_out_t         out_data_r, out_data_nxt;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_diff;
  logic [Q_W-1:0]    quo_sat;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign rem_sh   = {rem_r, dvd_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign quo_sat  = (|dvd_r[DIV_W-1:Q_W]) ? '1 : dvd_r[Q_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    thresh_nxt    = thresh_r;
    avoid_nxt     = avoid_r;
    alpha_nxt     = alpha_r;
    ratio_nxt     = ratio_r;
    nack_cnt_nxt  = nack_cnt_r;
    data_cnt_nxt  = data_cnt_r;
    ticks_en_nxt  = ticks_en_r;
    prod_nxt      = prod_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    div_alpha_nxt = div_alpha_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_OUT;
          case (in_ch.data.req_type)
            REQ_DATA: begin
              prod_nxt  = {{Q_W{1'b0}}, avoid_r} * {{Q_W{1'b0}}, alpha_r};
              state_nxt = S_DATA;
            end
            REQ_NACK: begin
              window_nxt   = (window_r > WIN_W'(1)) ? window_r - WIN_W'(1) : WIN_W'(1);
              thresh_nxt   = window_nxt;
              nack_cnt_nxt = sat_inc(nack_cnt_r);
              ticks_en_nxt = 1'b1;
              if (in_ch.data.pmin_present && (in_ch.data.pmin_value != '0)) begin
                if (ratio_r > in_ch.data.pmin_value) begin
                  dvd_nxt       = DIV_W'({ratio_r, 8'h00});
                  dvs_nxt       = DVS_W'(in_ch.data.pmin_value);
                  rem_nxt       = '0;
                  step_nxt      = '0;
                  div_alpha_nxt = 1'b1;
                  state_nxt     = S_DIV;
                end else begin
                  alpha_nxt = ALPHA_ONE;
                end
              end
            end
            REQ_TICK: begin
              if (ticks_en_r) begin
                nack_cnt_nxt = '0;
                data_cnt_nxt = '0;
                if (nack_cnt_r == '0) begin
                  ratio_nxt = ratio_blend(ratio_r, '0);
                end else begin
                  dvd_nxt       = DIV_W'({nack_cnt_r, 16'h0000});
                  dvs_nxt       = DVS_W'(nack_cnt_r) + DVS_W'(data_cnt_r);
                  rem_nxt       = '0;
                  step_nxt      = '0;
                  div_alpha_nxt = 1'b0;
                  state_nxt     = S_DIV;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DATA: begin
        if (window_r < thresh_r) begin
          window_nxt = (window_r == WIN_MAX) ? WIN_MAX : window_r + WIN_W'(1);
        end else if (CMP_W'(prod_r) >= CMP_W'({window_r, 8'h00})) begin
          window_nxt = (window_r == WIN_MAX) ? WIN_MAX : window_r + WIN_W'(1);
          avoid_nxt  = '0;
        end else begin
          avoid_nxt = sat_inc(avoid_r);
        end
        data_cnt_nxt = sat_inc(data_cnt_r);
        state_nxt    = S_OUT;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (!rem_diff[DVS_W]) begin
          rem_nxt = rem_diff[DVS_W-1:0];
          dvd_nxt = {dvd_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DVS_W-1:0];
          dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (div_alpha_r) begin
          alpha_nxt = quo_sat;
        end else begin
          ratio_nxt = ratio_blend(ratio_r, quo_sat);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.window_now    = 16'(window_r);
          out_data_nxt.threshold_now = 16'(thresh_r);
          out_data_nxt.alpha_now     = alpha_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_ch.valid) begin
      window_nxt = WIN_W'(cfg_ch.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WIN_W'(1);
      thresh_r    <= WIN_MAX;
      avoid_r     <= '0;
      alpha_r     <= ALPHA_ONE;
      ratio_r     <= '0;
      nack_cnt_r  <= '0;
      data_cnt_r  <= '0;
      ticks_en_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      thresh_r    <= thresh_nxt;
      avoid_r     <= avoid_nxt;
      alpha_r     <= alpha_nxt;
      ratio_r     <= ratio_nxt;
      nack_cnt_r  <= nack_cnt_nxt;
      data_cnt_r  <= data_cnt_nxt;
      ticks_en_r  <= ticks_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r      <= prod_nxt;
    dvd_r       <= dvd_nxt;
    dvs_r       <= dvs_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    div_alpha_r <= div_alpha_nxt;
    out_data_r  <= out_data_nxt;
  end

  `NSCW_ASSERT_IMP(a_alpha_floor, clk, rst_n, 1'b1, alpha_r >= ALPHA_ONE)
  `NSCW_ASSERT_NXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, state_r != S_IDLE)
  `NSCW_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_OUT))
  `NSCW_ASSERT_NXT(a_div_ends, clk, rst_n,
                   state_r == S_DIV && step_r == STEP_W'(DIV_W - 1), state_r == S_FIN)

endmodule
`default_nettype wire

FILE: tb/nack_scaled_congestion_window_tb.sv
`timescale 1ns / 100ps
module nack_scaled_congestion_window_tb;
  import nscw_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int         HALF_PERIOD = 5;
  localparam int         SETTLE_CYC  = 40;
  localparam int         DRAIN_LIMIT = 5000;
  localparam int         PHASES      = 6;
  localparam int         PHASE_ITEMS = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  nscw_chan_if #(.payload_t(nscw_in_t))    in_ch ();
  nscw_chan_if #(.payload_t(nscw_out_t))   out_ch ();
  nscw_chan_if #(.payload_t(logic [15:0])) cfg_ch ();

  nack_scaled_congestion_window uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted block state
  logic [15:0] cwnd;
  logic [15:0] ssthresh;
  logic [15:0] avoid_cnt;
  logic [15:0] alpha_q8;
  logic [15:0] ratio_q16;
  logic [15:0] nacks_seen;
  logic [15:0] datas_seen;
  bit          ticks_on;

  nscw_out_t expected_windows[$];
  int        errors = 0;
  bit        src_idle = 1'b1;
  bit        sink_idle = 1'b1;

  typedef struct {
    bit          is_cfg;
    logic [15:0] cfg_val;
    nscw_in_t    ev;
    bit          known;
    nscw_out_t   want;
  } plan_row_t;

  plan_row_t plan[$];

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic nscw_out_t advance_window(input nscw_in_t ev);
    nscw_out_t   r;
    logic [31:0] grow_lhs;
    logic [31:0] grow_rhs;
    logic [31:0] new_alpha;
    logic [31:0] frac;
    logic [16:0] total;
    logic [18:0] blend;
    case (ev.req_type)
      REQ_DATA: begin
        grow_lhs = {16'd0, avoid_cnt} * {16'd0, alpha_q8};
        grow_rhs = {8'd0, cwnd, 8'd0};
        if (cwnd < ssthresh) begin
          cwnd = bump16(cwnd);
        end else if (grow_lhs >= grow_rhs) begin
          cwnd = bump16(cwnd);
          avoid_cnt = '0;
        end else begin
          avoid_cnt = bump16(avoid_cnt);
        end
        datas_seen = bump16(datas_seen);
      end
      REQ_NACK: begin
        cwnd = (cwnd > 16'd1) ? cwnd - 16'd1 : 16'd1;
        ssthresh = cwnd;
        if (ev.pmin_present && ev.pmin_value != 16'd0) begin
          if (ratio_q16 > ev.pmin_value) begin
            new_alpha = {8'd0, ratio_q16, 8'd0} / {16'd0, ev.pmin_value};
            alpha_q8 = (new_alpha > 32'hFFFF) ? 16'hFFFF : new_alpha[15:0];
          end else begin
            alpha_q8 = 16'd256;
          end
        end
        nacks_seen = bump16(nacks_seen);
        ticks_on = 1'b1;
      end
      REQ_TICK: begin
        if (ticks_on) begin
          frac = '0;
          if (nacks_seen != 16'd0) begin
            total = {1'b0, nacks_seen} + {1'b0, datas_seen};
            frac = {nacks_seen, 16'd0} / {15'd0, total};
            if (frac > 32'hFFFF) frac = 32'hFFFF;
          end
          blend = {3'd0, ratio_q16} * 19'd7 + {3'd0, frac[15:0]};
          ratio_q16 = blend[18:3];
          nacks_seen = '0;
          datas_seen = '0;
        end
      end
      default: begin
      end
    endcase
    r.window_now = cwnd;
    r.threshold_now = ssthresh;
    r.alpha_now = alpha_q8;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    nscw_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_windows.size() == 0) begin
        report("result with no item pending");
      end else begin
        want = expected_windows.pop_front();
        if (out_ch.data.window_now !== want.window_now)
          report($sformatf("window_now %0d, want %0d",
                           out_ch.data.window_now, want.window_now));
        if (out_ch.data.threshold_now !== want.threshold_now)
          report($sformatf("threshold_now %0d, want %0d",
                           out_ch.data.threshold_now, want.threshold_now));
        if (out_ch.data.alpha_now !== want.alpha_now)
          report($sformatf("alpha_now %0d, want %0d",
                           out_ch.data.alpha_now, want.alpha_now));
      end
    end
  end

  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = sink_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && rst_n)) @(posedge clk);
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input nscw_in_t ev, input bit known, input nscw_out_t want);
    int        gap;
    nscw_out_t pred;
    gap = src_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= ev;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = advance_window(ev);
    expected_windows.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_windows.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_windows.size() != 0) begin
      report($sformatf("%0d results never arrived", expected_windows.size()));
      expected_windows.delete();
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_initial_window(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cwnd = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_cfg(input logic [15:0] v);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    row.ev = '0;
    row.known = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endtask

  task automatic add_item(input logic [1:0] req, input logic pres, input logic [15:0] pmin,
                          input bit known, input logic [15:0] w, input logic [15:0] t,
                          input logic [15:0] a);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = '0;
    row.ev.req_type = req;
    row.ev.pmin_present = pres;
    row.ev.pmin_value = pmin;
    row.known = known;
    row.want.window_now = w;
    row.want.threshold_now = t;
    row.want.alpha_now = a;
    plan.push_back(row);
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    nscw_in_t    ev;
    nscw_out_t   none;
    logic [15:0] wval;
    int          nack_pct;
    int          r;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    cwnd = 16'd1;
    ssthresh = 16'hFFFF;
    avoid_cnt = '0;
    alpha_q8 = 16'd256;
    ratio_q16 = '0;
    nacks_seen = '0;
    datas_seen = '0;
    ticks_on = 1'b0;
    none = '0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // reset state first, then window saturation near the top, then nack, alpha and tick cases
    add_item(REQ_TICK,    1'b1, 16'hFFFF, 1, 16'd1, 16'hFFFF, 16'd256);
    add_item(REQ_UNKNOWN, 1'b0, 16'h0000, 1, 16'd1, 16'hFFFF, 16'd256);
    add_cfg(16'd65534);
    add_item(REQ_TICK,    1'b1, 16'hFFFF, 1, 16'd65534, 16'hFFFF, 16'd256);
    add_item(REQ_UNKNOWN, 1'b1, 16'h5A5A, 1, 16'd65534, 16'hFFFF, 16'd256);
    add_item(REQ_DATA,    1'b0, 16'h0000, 1, 16'd65535, 16'hFFFF, 16'd256);
    add_item(REQ_DATA,    1'b1, 16'hFFFF, 1, 16'd65535, 16'hFFFF, 16'd256);
    add_item(REQ_NACK,    1'b0, 16'h0000, 1, 16'd65534, 16'd65534, 16'd256);
    add_cfg(16'd1);
    add_item(REQ_DATA,    1'b0, 16'h0000, 1, 16'd2, 16'd65534, 16'd256);
    add_item(REQ_DATA,    1'b0, 16'h0000, 1, 16'd3, 16'd65534, 16'd256);
    add_item(REQ_NACK,    1'b1, 16'h0000, 1, 16'd2, 16'd2, 16'd256);
    add_item(REQ_NACK,    1'b0, 16'hFFFF, 1, 16'd1, 16'd1, 16'd256);
    add_item(REQ_NACK,    1'b0, 16'h0000, 1, 16'd1, 16'd1, 16'd256);
    add_item(REQ_TICK,    1'b1, 16'h0001, 0, 0, 0, 0);
    add_item(REQ_NACK,    1'b1, 16'h0001, 1, 16'd1, 16'd1, 16'hFFFF);
    add_item(REQ_DATA,    1'b0, 16'h0000, 0, 0, 0, 0);
    add_item(REQ_DATA,    1'b1, 16'h0001, 0, 0, 0, 0);
    add_item(REQ_NACK,    1'b1, 16'hFFFF, 0, 0, 0, 0);
    add_item(REQ_TICK,    1'b0, 16'h0000, 0, 0, 0, 0);
    add_item(REQ_TICK,    1'b0, 16'h0000, 0, 0, 0, 0);
    add_item(REQ_NACK,    1'b1, 16'h0100, 0, 0, 0, 0);
    add_cfg(16'd16);
    add_item(REQ_DATA,    1'b0, 16'h0000, 0, 0, 0, 0);
    add_item(REQ_DATA,    1'b0, 16'h0000, 0, 0, 0, 0);
    add_item(REQ_NACK,    1'b1, 16'h0040, 0, 0, 0, 0);
    add_item(REQ_DATA,    1'b0, 16'h0000, 0, 0, 0, 0);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_initial_window(plan[i].cfg_val);
      end else begin
        send_item(plan[i].ev, plan[i].known, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        1: wval = 16'hFFFF;
        3: wval = 16'd1;
        default: wval = 16'($urandom_range(1, 65535));
      endcase
      write_initial_window(wval);
      nack_pct = $urandom_range(5, 60);
      src_idle = (ph != 2);
      sink_idle = (ph != 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        r = $urandom_range(0, 99);
        if (r < 3) ev.req_type = REQ_UNKNOWN;
        else if (r < 3 + nack_pct) ev.req_type = REQ_NACK;
        else if (r < 15 + nack_pct) ev.req_type = REQ_TICK;
        else ev.req_type = REQ_DATA;
        ev.pmin_present = ($urandom_range(0, 9) < 7);
        case ($urandom_range(0, 9))
          0, 1, 2: ev.pmin_value = 16'($urandom_range(1, 4096));
          3:       ev.pmin_value = 16'h0000;
          4, 5:    ev.pmin_value = 16'($urandom);
          6:       ev.pmin_value = 16'hFFFF;
          7, 8:    ev.pmin_value = ratio_q16 + 16'($urandom_range(0, 8)) - 16'd4;
          default: ev.pmin_value = 16'h0001;
        endcase
        send_item(ev, 1'b0, none);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
